// File: sv/sfr_pkg.sv
// Shared types, constants and helpers of the streaming find-and-replace block.
// No dependencies; used by sfr_match_cell, sfr_out_cell and stream_find_replace.
package sfr_pkg;

   localparam int BYTE_W    = 8;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;
   localparam int LEN_W     = 4;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_BYTES      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 3'd3;

   // one output word as it sits in the queue
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              done;
   } sfr_word_type;

   // per-cell queue control
   typedef struct packed {
      logic pop;
      logic load;
   } sfr_qctl_type;

   // clamp a length register: zero acts as one, above the maximum acts as the maximum
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v,
                                                input logic [LEN_W-1:0] maxv);
      logic [LEN_W-1:0] r;
      if (v == '0) begin
         r = LEN_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: sv/stream_find_replace.sv
// Top level of the streaming find-and-replace block.
// Depends on sfr_pkg, sfr_match_cell and sfr_out_cell.
//
// Usage:
//   Input words (req_in_byte, req_end_of_stream) arrive on a valid/ready
//   channel, one text byte per word. Output words (rsp_out_byte,
//   rsp_last_of_run, rsp_stream_done) leave on a valid/ready channel.
//   A row of match cells holds the pending bytes that may still begin the
//   pattern and combinationally compares the whole window to the pattern;
//   each accepted byte yields zero to max(PATTERN_MAX, REPLACE_MAX) words.
//   The words of one input byte enter a shifting output queue of
//   2*max(PATTERN_MAX, REPLACE_MAX) cells in the cycle of acceptance, behind
//   the words still queued. Throughput is one input byte per cycle while
//   each byte gives at most one word and rsp_ready is high; the queue drains
//   one word per cycle while rsp_ready is high, so req_ready drops while it
//   holds more than max(PATTERN_MAX, REPLACE_MAX) words. A stalled receiver
//   fills the queue and then holds off the sender; nothing is lost. The csr
//   port writes pattern and replacement registers; the user must do so only
//   while idle, which the block itself does not enforce. A pattern write
//   drops any pending bytes. Reset empties the pending bytes and the queue and
//   sets both byte registers to zero and both lengths to one.
module stream_find_replace #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_wr_en,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfr_pkg::CSR_W-1:0]       csr_data,
   // input channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sfr_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                            req_end_of_stream,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sfr_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_last_of_run,
   output logic                            rsp_stream_done
);

   localparam int BW      = sfr_pkg::BYTE_W;
   localparam int LW      = sfr_pkg::LEN_W;
   localparam int CW      = $clog2(PATTERN_MAX + 1);
   localparam int RES_MAX = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
   localparam int RCW     = $clog2(RES_MAX + 1);
   localparam int RIW     = (RES_MAX > 1) ? $clog2(RES_MAX) : 1;
   localparam int QD      = 2 * RES_MAX;
   localparam int QCW     = $clog2(QD + 1);

   // configuration registers
   logic [PATTERN_MAX-1:0][BW-1:0] pat_ff;
   logic [LW-1:0]                  plen_ff;
   logic [REPLACE_MAX-1:0][BW-1:0] rep_ff;
   logic [LW-1:0]                  rlen_ff;
   logic [LW-1:0]                  plen;
   logic [LW-1:0]                  rlen;

   // pending bytes
   logic [CW-1:0]                  held_cnt_ff;
   logic [CW-1:0]                  held_cnt_in;
   logic [CW-1:0]                  n_eff;
   logic [PATTERN_MAX-1:0][BW-1:0] win;
   logic [PATTERN_MAX-1:0][PATTERN_MAX-1:0] eq_all;
   logic [PATTERN_MAX-1:0][BW-1:0] shift_byte;
   logic [PATTERN_MAX-1:0]         match;
   logic [CW-1:0]                  len;
   logic [CW-1:0]                  start;
   logic                           full;
   logic                           eos;
   logic                           acc;

   // results of this byte
   logic [RCW-1:0]                 cnt;
   sfr_pkg::sfr_word_type          res [RES_MAX];

   // output queue
   logic [QCW-1:0]                 q_cnt_ff;
   logic [QCW-1:0]                 q_cnt_in;
   logic [QCW-1:0]                 base;
   logic [QCW-1:0]                 add_cnt;
   logic                           pop;
   sfr_pkg::sfr_qctl_type          qctl   [QD];
   sfr_pkg::sfr_word_type          q_load [QD];
   sfr_pkg::sfr_word_type          q_word [QD+1];
   logic [QD:0]                    q_valid;

   assign plen = sfr_pkg::eff_len(plen_ff, LW'(PATTERN_MAX));
   assign rlen = sfr_pkg::eff_len(rlen_ff, LW'(REPLACE_MAX));

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff  <= '0;
         plen_ff <= LW'(1);
         rep_ff  <= '0;
         rlen_ff <= LW'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            sfr_pkg::REG_PATTERN_BYTES: begin
               pat_ff <= csr_data[PATTERN_MAX*BW-1:0];
            end
            sfr_pkg::REG_PATTERN_LENGTH: begin
               plen_ff <= csr_data[LW-1:0];
            end
            sfr_pkg::REG_REPLACEMENT_BYTES: begin
               rep_ff <= csr_data[REPLACE_MAX*BW-1:0];
            end
            sfr_pkg::REG_REPLACEMENT_LENGTH: begin
               rlen_ff <= csr_data[LW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign eos  = req_end_of_stream;
   assign acc  = req_valid && req_ready;
   assign n_eff = (held_cnt_ff >= CW'(plen)) ? '0 : held_cnt_ff;
   assign len  = n_eff + CW'(1);

   // row of match cells
   genvar gk;
   generate
      for (gk = 0; gk < PATTERN_MAX; gk++) begin : g_cell
         sfr_match_cell #(
            .PMAX (PATTERN_MAX),
            .IDX  (gk),
            .CW   (CW)
         ) u_cell (
            .clock     (clock),
            .held_cnt  (n_eff),
            .in_byte   (req_in_byte),
            .pattern   (pat_ff),
            .load      (acc),
            .load_byte (shift_byte[gk]),
            .win_byte  (win[gk]),
            .eq        (eq_all[gk])
         );
      end
   endgenerate

   // a start is good when the rest of the window is a pattern prefix
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         match[i] = 1'b1;
         for (int k = 0; k < PATTERN_MAX; k++) begin
            if (k >= i) begin
               if ((CW'(k) < len) && !eq_all[k][k-i]) begin
                  match[i] = 1'b0;
               end
            end
         end
      end
   end

   // pick the earliest good start; an empty rest always qualifies
   always_comb begin
      start = len;
      for (int i = PATTERN_MAX - 1; i >= 0; i--) begin
         if ((CW'(i) < len) && match[i]) begin
            start = CW'(i);
         end
      end
   end

   assign full = (start == '0) && (len == CW'(plen));

   // shift the kept rest down to position zero
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         shift_byte[k] = win[k];
         for (int s = 0; s < PATTERN_MAX; s++) begin
            if (k + s < PATTERN_MAX) begin
               if (start == CW'(s)) begin
                  shift_byte[k] = win[k+s];
               end
            end
         end
      end
   end

   // pending byte count
   always_comb begin
      held_cnt_in = held_cnt_ff;
      if (acc) begin
         if (full || eos) begin
            held_cnt_in = '0;
         end else begin
            held_cnt_in = len - start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= '0;
      end else if (csr_wr_en && ((csr_index == sfr_pkg::REG_PATTERN_BYTES) ||
                                 (csr_index == sfr_pkg::REG_PATTERN_LENGTH))) begin
         held_cnt_ff <= '0;
      end else begin
         held_cnt_ff <= held_cnt_in;
      end
   end

   // result words of this byte: replacement, or the window prefix
   always_comb begin
      if (full) begin
         cnt = RCW'(rlen);
      end else if (eos) begin
         cnt = RCW'(len);
      end else begin
         cnt = RCW'(start);
      end
   end

   always_comb begin
      for (int j = 0; j < RES_MAX; j++) begin
         res[j].data = '0;
         if (full) begin
            if (j < REPLACE_MAX) begin
               res[j].data = rep_ff[j];
            end
         end else begin
            if (j < PATTERN_MAX) begin
               res[j].data = win[j];
            end
         end
         res[j].last = (RCW'(j) + RCW'(1) == cnt);
         res[j].done = eos && res[j].last;
      end
   end

   // queue control: admit a byte only while room for a full run remains
   assign req_ready = (q_cnt_ff <= QCW'(QD - RES_MAX));
   assign pop       = q_valid[0] && rsp_ready;
   assign base      = pop ? (q_cnt_ff - QCW'(1)) : q_cnt_ff;
   assign add_cnt   = acc ? QCW'(cnt) : '0;
   assign q_cnt_in  = q_cnt_ff - (pop ? QCW'(1) : QCW'(0)) + add_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
      end else begin
         q_cnt_ff <= q_cnt_in;
      end
   end

   // per-cell load select
   always_comb begin
      for (int j = 0; j < QD; j++) begin
         logic [QCW-1:0] off;
         off          = QCW'(j) - base;
         qctl[j].pop  = pop;
         qctl[j].load = acc && (QCW'(j) >= base) && (QCW'(j) < base + add_cnt);
         q_load[j]    = res[off[RIW-1:0]];
      end
   end

   // tail of the chain feeds an empty word
   assign q_word[QD]  = '0;
   assign q_valid[QD] = 1'b0;

   genvar gq;
   generate
      for (gq = 0; gq < QD; gq++) begin : g_q
         sfr_out_cell u_q (
            .clock      (clock),
            .reset      (reset),
            .ctl        (qctl[gq]),
            .load_word  (q_load[gq]),
            .next_word  (q_word[gq+1]),
            .next_valid (q_valid[gq+1]),
            .word       (q_word[gq]),
            .valid      (q_valid[gq])
         );
      end
   endgenerate

   // head of the queue drives the result channel
   assign rsp_valid       = q_valid[0];
   assign rsp_out_byte    = q_word[0].data;
   assign rsp_last_of_run = q_word[0].last;
   assign rsp_stream_done = q_word[0].done;

endmodule

// File: sv/sfr_match_cell.sv
// One window position: holds a pending byte and compares the window byte at
// this position against every pattern byte. Depends on sfr_pkg.
module sfr_match_cell #(
   parameter int PMAX = 8,
   parameter int IDX  = 0,
   parameter int CW   = 4
) (
   input  logic                                 clock,
   input  logic [CW-1:0]                        held_cnt,
   input  logic [sfr_pkg::BYTE_W-1:0]           in_byte,
   input  logic [PMAX-1:0][sfr_pkg::BYTE_W-1:0] pattern,
   input  logic                                 load,
   input  logic [sfr_pkg::BYTE_W-1:0]           load_byte,
   output logic [sfr_pkg::BYTE_W-1:0]           win_byte,
   output logic [PMAX-1:0]                      eq
);

   logic [sfr_pkg::BYTE_W-1:0] held_ff;
   logic [sfr_pkg::BYTE_W-1:0] held_in;

   // window byte: held byte below the fill level, the new byte at and above it
   assign win_byte = (CW'(IDX) < held_cnt) ? held_ff : in_byte;

   // compare against each pattern byte
   always_comb begin
      for (int j = 0; j < PMAX; j++) begin
         eq[j] = (win_byte == pattern[j]);
      end
   end

   // hold or take the byte shifted in from the window
   assign held_in = load ? load_byte : held_ff;

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

// File: sv/sfr_out_cell.sv
// One slot of the output queue: loads a fresh word or takes its neighbor's
// word when the head is popped. Depends on sfr_pkg.
module sfr_out_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sfr_pkg::sfr_qctl_type ctl,
   input  sfr_pkg::sfr_word_type load_word,
   input  sfr_pkg::sfr_word_type next_word,
   input  logic                  next_valid,
   output sfr_pkg::sfr_word_type word,
   output logic                  valid
);

   sfr_pkg::sfr_word_type word_ff;
   sfr_pkg::sfr_word_type word_in;
   logic                  valid_ff;
   logic                  valid_in;

   // load wins over shift; otherwise advance on pop, else hold
   always_comb begin
      if (ctl.load) begin
         word_in  = load_word;
         valid_in = 1'b1;
      end else if (ctl.pop) begin
         word_in  = next_word;
         valid_in = next_valid;
      end else begin
         word_in  = word_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign word  = word_ff;
   assign valid = valid_ff;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for stream_find_replace: sends text words with random idling and stalls,
// predicts the replaced text in a scoreboard class and checks each output word in order.
// Depends on sfr_pkg and the stream_find_replace RTL.

class replace_predictor;
   localparam int PAT_MAX = 8;
   localparam int REP_MAX = 8;

   logic [63:0]  pat_bytes = '0;
   logic [3:0]   pat_len   = 4'd1;
   logic [63:0]  rep_bytes = '0;
   logic [3:0]   rep_len   = 4'd1;
   logic [7:0]   held [PAT_MAX];
   int unsigned  held_cnt  = 0;
   sfr_pkg::sfr_word_type pending_words[$];
   int unsigned  word_cnt  = 0;
   int           errors    = 0;

   // zero acts as one, anything above the maximum acts as the maximum
   function int unsigned clamp_len(logic [3:0] v, int unsigned top);
      if (v == 4'd0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function void write_reg(logic [sfr_pkg::CSR_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
         sfr_pkg::REG_PATTERN_BYTES: begin
            pat_bytes = val;
            held_cnt  = 0;
         end
         sfr_pkg::REG_PATTERN_LENGTH: begin
            pat_len  = val[3:0];
            held_cnt = 0;
         end
         sfr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes = val;
         sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len   = val[3:0];
         default: ;
      endcase
   endfunction

   // work out the words caused by one accepted text byte
   function void note_byte(logic [7:0] value, logic eos);
      logic [7:0]  win [PAT_MAX];
      logic [7:0]  out_bytes[$];
      sfr_pkg::sfr_word_type w;
      int unsigned plen, rlen, n, len, start, k;
      bit          hit;
      plen = clamp_len(pat_len, PAT_MAX);
      rlen = clamp_len(rep_len, REP_MAX);
      n = held_cnt;
      if (n >= plen) n = 0;
      for (k = 0; k < n; k++) win[k] = held[k];
      win[n] = value;
      len = n + 1;
      // find the earliest start whose tail is still a pattern prefix
      for (start = 0; start < len; start++) begin
         hit = 1'b1;
         for (k = 0; k < len - start; k++) begin
            if (win[start + k] != pat_bytes[8*k +: 8]) hit = 1'b0;
         end
         if (hit) break;
      end
      if (start == 0 && len == plen) begin
         for (k = 0; k < rlen; k++) out_bytes.push_back(rep_bytes[8*k +: 8]);
         held_cnt = 0;
      end else begin
         for (k = 0; k < start; k++) out_bytes.push_back(win[k]);
         if (eos) begin
            for (k = start; k < len; k++) out_bytes.push_back(win[k]);
         end else begin
            for (k = start; k < len; k++) held[k - start] = win[k];
            held_cnt = len - start;
         end
      end
      if (eos) held_cnt = 0;
      foreach (out_bytes[i]) begin
         w.data = out_bytes[i];
         w.last = (i == out_bytes.size() - 1);
         w.done = w.last && eos;
         pending_words.push_back(w);
      end
   endfunction

   task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
   endtask

   // compare one output word against the oldest expectation
   task check_word(logic [7:0] data, logic last, logic done);
      sfr_pkg::sfr_word_type exp_word;
      if (pending_words.size() == 0) begin
         report($sformatf("word %0d (%0h) arrived with nothing expected", word_cnt, data));
      end else begin
         exp_word = pending_words.pop_front();
         if (data !== exp_word.data)
            report($sformatf("word %0d out_byte %0h, want %0h", word_cnt, data,
                             exp_word.data));
         if (last !== exp_word.last)
            report($sformatf("word %0d last_of_run %0b, want %0b", word_cnt, last,
                             exp_word.last));
         if (done !== exp_word.done)
            report($sformatf("word %0d stream_done %0b, want %0b", word_cnt, done,
                             exp_word.done));
      end
      word_cnt++;
   endtask
endclass

module tb_top;

   localparam int QUIET_LIMIT = 2000;
   localparam int IW          = sfr_pkg::CSR_IDX_W;
   localparam logic [IW-1:0] REG_SPARE_FIRST = sfr_pkg::REG_REPLACEMENT_LENGTH + 1'b1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic [IW-1:0]                 csr_index = '0;
   logic [sfr_pkg::CSR_W-1:0]     csr_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [sfr_pkg::BYTE_W-1:0]    req_in_byte = '0;
   logic                          req_end_of_stream = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [sfr_pkg::BYTE_W-1:0]    rsp_out_byte;
   logic                          rsp_last_of_run;
   logic                          rsp_stream_done;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned quiet_cycles = 0;
   replace_predictor sb;

   stream_find_replace u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_stream_done   (rsp_stream_done)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // stall the output side at the phase rate
   always @(posedge clock) begin
      rsp_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // note accepted text words, check accepted output words
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_in_byte, req_end_of_stream);
         if (rsp_valid && rsp_ready) sb.check_word(rsp_out_byte, rsp_last_of_run,
                                                   rsp_stream_done);
      end
   end

   // count cycles where no word moves and no register is written
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("timeout after %0d quiet cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // raise valid after a random gap and hold it until the word is taken
   task automatic send_byte(input logic [7:0] value, input logic eos);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= value;
      req_end_of_stream <= eos;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait for every expected word, then let the block settle
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_wr_en high; the caller lowers it after the last write
   task automatic write_reg(input logic [IW-1:0] idx, input logic [63:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic set_config(input logic [63:0] pat, input logic [3:0] plen,
                             input logic [63:0] rep, input logic [3:0] rlen,
                             input bit add_spare);
      logic [63:0] junk;
      junk = rand64();
      if (add_spare) write_reg(REG_SPARE_FIRST + IW'($urandom_range(3)), rand64());
      write_reg(sfr_pkg::REG_PATTERN_BYTES, pat);
      write_reg(sfr_pkg::REG_PATTERN_LENGTH, {junk[63:4], plen});
      write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, rep);
      junk = rand64();
      write_reg(sfr_pkg::REG_REPLACEMENT_LENGTH, {junk[63:4], rlen});
      csr_wr_en <= 1'b0;
   endtask

   // build text from whole patterns, partial and broken prefixes and noise
   task automatic send_stream(input int unsigned count, input bit with_eos);
      logic [7:0]  text[$];
      logic [63:0] pat;
      int unsigned plen, cut, k;
      pat  = sb.pat_bytes;
      plen = sb.clamp_len(sb.pat_len, sb.PAT_MAX);
      while (text.size() < count) begin
         case ($urandom_range(9))
            0, 1, 2, 3: for (k = 0; k < plen; k++) text.push_back(pat[8*k +: 8]);
            4, 5: begin
               cut = $urandom_range(plen - 1);
               for (k = 0; k < cut; k++) text.push_back(pat[8*k +: 8]);
            end
            6: begin
               cut = $urandom_range(plen - 1);
               for (k = 0; k < cut; k++) text.push_back(pat[8*k +: 8]);
               text.push_back(8'($urandom_range(255)));
            end
            default: begin
               k = $urandom_range(plen - 1);
               if ($urandom_range(1)) text.push_back(pat[8*k +: 8]);
               else text.push_back(8'($urandom_range(255)));
            end
         endcase
      end
      for (k = 0; k < count; k++) send_byte(text[k], with_eos && (k == count - 1));
   endtask

   initial begin
      logic [63:0] pat;
      logic [7:0]  sym_a, sym_b;
      logic [3:0]  plen, rlen;
      int unsigned left, chunk, k;
      bit          tail_eos;

      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings replace a zero byte by a zero byte
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      wait_drain();

      // directed: spare indexes do nothing; overlapping prefix "aab" -> "XY"
      write_reg(REG_SPARE_FIRST, rand64());
      write_reg(REG_SPARE_FIRST + 3'd3, rand64());
      set_config(64'hA5A5_A5A5_A562_6161, 4'd3, 64'h5A5A_5A5A_5A5A_5958, 4'd2, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h61, 1'b1);
      wait_drain();

      // directed: zero pattern length acts as one, oversize replacement as eight
      set_config(64'hFFFF_FFFF_FFFF_FF71, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd15, 1'b0);
      send_byte(8'h71, 1'b0);
      send_byte(8'h71, 1'b0);
      send_byte(8'h72, 1'b1);
      wait_drain();

      // directed: oversize pattern length acts as eight
      set_config(64'h8070_6050_4030_2010, 4'd15, 64'h1234_5678_9ABC_DEEE, 4'd1, 1'b0);
      for (k = 1; k <= 8; k++) send_byte(8'(k * 16), 1'b0);
      // replacement rewrite keeps the held prefix, end of text flushes it
      send_byte(8'h10, 1'b0);
      send_byte(8'h20, 1'b0);
      wait_drain();
      write_reg(sfr_pkg::REG_REPLACEMENT_BYTES, rand64());
      csr_wr_en <= 1'b0;
      send_byte(8'h30, 1'b1);
      // pattern rewrite drops the held prefix
      send_byte(8'h10, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h30, 1'b0);
      wait_drain();
      write_reg(sfr_pkg::REG_PATTERN_LENGTH, 64'd8);
      csr_wr_en <= 1'b0;
      send_byte(8'h78, 1'b1);

      // random: four idling phases, two settings each
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 67; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 67; end
            default: begin idle_pct = 25; stall_pct = 25; end
         endcase
         for (int seg = 0; seg < 2; seg++) begin
            wait_drain();
            if (phase == 0 && seg == 0) begin
               plen = 4'd1;
               rlen = 4'd8;
            end else if (phase == 0) begin
               plen = 4'd8;
               rlen = 4'd1;
            end else begin
               plen = 4'($urandom_range(15));
               rlen = 4'($urandom_range(15));
            end
            // a two-symbol pattern gives plenty of self-overlap
            if ($urandom_range(1)) begin
               pat = rand64();
            end else begin
               sym_a = 8'($urandom_range(255));
               sym_b = 8'($urandom_range(255));
               for (k = 0; k < 8; k++) pat[8*k +: 8] = $urandom_range(1) ? sym_a : sym_b;
            end
            set_config(pat, plen, rand64(), rlen, $urandom_range(3) == 0);
            // the last stream may stop short so the next rewrite drops held bytes
            tail_eos = $urandom_range(1);
            left = 18;
            while (left > 0) begin
               chunk = $urandom_range(12, 1);
               if (chunk > left) chunk = left;
               send_stream(chunk, (chunk == left) ? tail_eos : 1'b1);
               left -= chunk;
               if ($urandom_range(3) == 0) wait_drain();
            end
         end
      end

      wait_drain();
      if (sb.errors == 0 && sb.pending_words.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
